>>> design/mctb_pkg.sv
// ---------------------------------------------------------------------------
// mctb_pkg
// Shared types and constants for the multi-channel timer bank: command
// codes, count modes, the input and result words and the per-channel record.
// ---------------------------------------------------------------------------
package mctb_pkg;

    localparam int CHANNELS    = 8;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int FCH_W       = 3;

    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] MIN_PERIOD = 32'd2;

    typedef logic [CH_W-1:0] t_ch;

    typedef enum logic [3:0] {
        MODE_TICK      = 4'd0,
        MODE_ALLOC     = 4'd1,
        MODE_RELEASE   = 4'd2,
        MODE_CONFIG    = 4'd3,
        MODE_ENABLE    = 4'd4,
        MODE_DISABLE   = 4'd5,
        MODE_START     = 4'd6,
        MODE_STOP      = 4'd7,
        MODE_HANDLER   = 4'd8,
        MODE_CLR_COUNT = 4'd9,
        MODE_PENDING   = 4'd10,
        MODE_CLR_PEND  = 4'd11,
        MODE_READ      = 4'd12
    } t_mode;

    typedef enum logic [1:0] {
        CM_ONESHOT  = 2'd0,
        CM_PERIODIC = 2'd1,
        CM_COMPARE  = 2'd2,
        CM_FREE     = 2'd3
    } t_cmode;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  channel;
        logic [1:0]  count_mode;
        logic [31:0] period;
        logic        enable_on_config;
        logic        handler_present;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [31:0]      value;
        logic             fired;
        logic [FCH_W-1:0] fired_channel;
        logic             callback_event;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [1:0]  count_mode;
        logic [31:0] period;
        logic [31:0] count;
        logic        enabled;
        logic        running;
        logic        in_error;
        logic        pending;
        logic        overflowed;
    } t_entry;

    localparam t_entry ENTRY_CLEAR = '{
        count_mode: 2'd0,
        period:     32'd0,
        count:      32'd0,
        enabled:    1'b0,
        running:    1'b0,
        in_error:   1'b1,
        pending:    1'b0,
        overflowed: 1'b0
    };

    typedef struct packed {
        t_entry      entry;
        logic        mem_we;
        logic        status;
        logic [31:0] value;
        logic        expire;
        logic        alloc_we;
        logic        alloc_val;
        logic        hnd_we;
        logic        hnd_val;
    } t_upd;

endpackage

>>> design/mctb_update.sv
// ---------------------------------------------------------------------------
// mctb_update
// Modify stage of the read-modify-write loop: given one channel record as
// read from the channel memory, work out the record to write back and the
// result of a tick step or of a command.
// ---------------------------------------------------------------------------
module mctb_update
    import mctb_pkg::*;
(
    input  logic   i_tick,
    input  t_in    i_item,
    input  t_ch    i_idx,
    input  t_entry i_entry,
    input  logic   i_alloc,
    input  logic   i_handler,
    input  logic   i_free_found,
    output t_upd   o_upd
);

    always_comb begin
        t_entry      e;
        t_upd        u;
        logic [31:0] cnt1;
        logic        in_rng;

        e      = i_entry;
        u      = '0;
        u.status = 1'b1;
        cnt1   = i_entry.count + 32'd1;
        in_rng = i_item.channel < 8'(CHANNELS);

        if (i_tick) begin
            u.mem_we = 1'b1;
            u.status = 1'b0;
            if (i_alloc && e.enabled && !e.in_error && e.running) begin
                e.count = cnt1;
                if (cnt1 == ALL_ONES) begin
                    e.overflowed = 1'b1;
                end
                case (t_cmode'(e.count_mode))
                    CM_ONESHOT: begin
                        if (cnt1 >= e.period) begin
                            u.expire  = 1'b1;
                            e.running = 1'b0;
                            e.count   = '0;
                        end
                    end
                    CM_PERIODIC: begin
                        if (cnt1 == e.period) begin
                            u.expire = 1'b1;
                            e.count  = '0;
                        end
                    end
                    CM_COMPARE: begin
                        if (cnt1 == e.period) begin
                            u.expire = 1'b1;
                        end
                    end
                    default: ;
                endcase
                // a handler consumes the expiry, so pending stays clear
                if (u.expire) begin
                    e.pending = !i_handler;
                end
            end
        end else if (t_mode'(i_item.mode) == MODE_ALLOC) begin
            if (i_free_found) begin
                e           = ENTRY_CLEAR;
                u.mem_we    = 1'b1;
                u.alloc_we  = 1'b1;
                u.alloc_val = 1'b1;
                u.status    = 1'b0;
                u.value     = 32'(i_idx);
            end
        end else if (in_rng) begin
            case (t_mode'(i_item.mode))
                MODE_RELEASE: begin
                    e           = ENTRY_CLEAR;
                    u.mem_we    = 1'b1;
                    u.alloc_we  = 1'b1;
                    u.alloc_val = 1'b0;
                    u.status    = 1'b0;
                end
                MODE_CONFIG: begin
                    if (i_alloc) begin
                        u.mem_we     = 1'b1;
                        e.in_error   = 1'b0;
                        e.count_mode = i_item.count_mode;
                        if (t_cmode'(i_item.count_mode) == CM_FREE) begin
                            e.period = '0;
                        end else begin
                            e.period   = i_item.period;
                            e.in_error = (i_item.period < MIN_PERIOD);
                        end
                        if (!e.in_error) begin
                            if (i_item.enable_on_config) begin
                                e.enabled = 1'b1;
                            end
                            u.status = 1'b0;
                        end
                    end
                end
                MODE_ENABLE: begin
                    if (i_alloc && !e.in_error) begin
                        u.mem_we  = 1'b1;
                        e.enabled = 1'b1;
                        u.status  = 1'b0;
                    end
                end
                MODE_DISABLE: begin
                    if (i_alloc) begin
                        u.mem_we  = 1'b1;
                        e.enabled = 1'b0;
                        u.status  = 1'b0;
                    end
                end
                MODE_START: begin
                    if (i_alloc) begin
                        u.mem_we = 1'b1;
                        if (!e.in_error) begin
                            e.enabled = 1'b1;
                        end
                        // an enabled channel in error still starts
                        if (e.enabled) begin
                            e.running = 1'b1;
                            u.status  = 1'b0;
                        end
                    end
                end
                MODE_STOP: begin
                    if (i_alloc) begin
                        u.mem_we  = 1'b1;
                        e.running = 1'b0;
                        u.status  = 1'b0;
                    end
                end
                MODE_HANDLER: begin
                    if (i_alloc) begin
                        u.hnd_we  = 1'b1;
                        u.hnd_val = i_item.handler_present;
                        u.status  = 1'b0;
                    end
                end
                MODE_CLR_COUNT: begin
                    u.mem_we = 1'b1;
                    e.count  = '0;
                    u.status = 1'b0;
                end
                MODE_PENDING: begin
                    u.value  = {31'd0, e.pending};
                    u.status = 1'b0;
                end
                MODE_CLR_PEND: begin
                    u.mem_we  = 1'b1;
                    e.pending = 1'b0;
                    u.status  = 1'b0;
                end
                MODE_READ: begin
                    u.value  = e.count;
                    u.status = 1'b0;
                end
                default: ;
            endcase
        end

        u.entry = e;
        o_upd   = u;
    end

endmodule

>>> design/multi_channel_timer_bank.sv
// ---------------------------------------------------------------------------
// multi_channel_timer_bank
// Bank of 32-bit timers with one-shot, periodic, compare-continue and
// free-run modes, driven by tick words and command words.
// ---------------------------------------------------------------------------
// Channel records (mode, period, count and flags) live in one memory with
// a write port and a registered read port; allocation and handler marks sit
// in flops. A command word is accepted in idle, its record is read into a
// register, and in the modify state its result word is loaded into the
// output register. A tick word sweeps the memory one channel per cycle while
// no earlier expiry word is held back by the output side, reading the next
// channel while writing back the current one. The input stays stalled until
// the block is back in idle, and a stalled output holds result words back.
// One result word is emitted per expiring channel in ascending
// order (at most MAX_RESULTS), or one word with fired low when none expires;
// the final word of every input word carries last. No clearing pass is
// needed after reset.
module multi_channel_timer_bank
    import mctb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_word,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    localparam t_ch LAST_CH = t_ch'(CHANNELS - 1);

    // channel memory and its read port
    t_entry              r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    t_entry              r_rd;
    logic                r_rd_valid;

    logic [CHANNELS-1:0] r_alloc;
    logic [CHANNELS-1:0] r_handler;

    t_state           r_state, n_state;
    t_in              r_item, n_item;
    t_ch              r_addr, n_addr;
    logic             r_free_found, n_free_found;
    logic             r_hold_valid, n_hold_valid;
    logic [FCH_W-1:0] r_hold_ch, n_hold_ch;
    logic             r_hold_cb, n_hold_cb;
    logic [CNT_W-1:0] r_nrep, n_nrep;
    logic             r_out_valid;
    t_out             r_out;

    logic   rd_en;
    t_ch    rd_addr;
    logic   wr_en;
    logic   commit;
    logic   out_load;
    t_out   out_word;
    logic   out_free;
    logic   is_tick;
    logic   report;
    logic   push;
    t_ch    free_idx;
    logic   free_found;
    t_entry entry;
    t_upd   upd;

    // lowest free channel
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_idx   = t_ch'(i);
                free_found = 1'b1;
            end
        end
    end

    assign entry    = r_rd_valid ? r_rd : ENTRY_CLEAR;
    assign is_tick  = (t_mode'(r_item.mode) == MODE_TICK);
    assign out_free = !r_out_valid || !i_out_stall;

    mctb_update u_update (
        .i_tick       (is_tick),
        .i_item       (r_item),
        .i_idx        (r_addr),
        .i_entry      (entry),
        .i_alloc      (r_alloc[r_addr]),
        .i_handler    (r_handler[r_addr]),
        .i_free_found (r_free_found),
        .o_upd        (upd)
    );

    assign report = upd.expire && (r_nrep < CNT_W'(MAX_RESULTS));
    assign push   = report && r_hold_valid;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_addr       = r_addr;
        n_free_found = r_free_found;
        n_hold_valid = r_hold_valid;
        n_hold_ch    = r_hold_ch;
        n_hold_cb    = r_hold_cb;
        n_nrep       = r_nrep;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        wr_en        = 1'b0;
        commit       = 1'b0;
        out_load     = 1'b0;
        out_word     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_word;
                    rd_en  = 1'b1;
                    if (t_mode'(i_in_word.mode) == MODE_TICK) begin
                        rd_addr = '0;
                    end else if (t_mode'(i_in_word.mode) == MODE_ALLOC) begin
                        rd_addr = free_idx;
                    end else begin
                        rd_addr = i_in_word.channel[CH_W-1:0];
                    end
                    n_addr       = rd_addr;
                    n_free_found = free_found;
                    n_hold_valid = 1'b0;
                    n_nrep       = '0;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                if (is_tick) begin
                    // hold the sweep while an earlier expiry word cannot leave
                    if (!push || out_free) begin
                        wr_en  = upd.mem_we;
                        commit = 1'b1;
                        if (push) begin
                            out_load                = 1'b1;
                            out_word.fired          = 1'b1;
                            out_word.fired_channel  = r_hold_ch;
                            out_word.callback_event = r_hold_cb;
                        end
                        if (report) begin
                            n_hold_valid = 1'b1;
                            n_hold_ch    = FCH_W'(r_addr);
                            n_hold_cb    = r_handler[r_addr];
                            n_nrep       = r_nrep + CNT_W'(1);
                        end
                        if (r_addr == LAST_CH) begin
                            n_state = S_FIN;
                        end else begin
                            n_addr  = r_addr + t_ch'(1);
                            rd_en   = 1'b1;
                            rd_addr = n_addr;
                        end
                    end
                end else if (out_free) begin
                    wr_en          = upd.mem_we;
                    commit         = 1'b1;
                    out_load       = 1'b1;
                    out_word.status = upd.status;
                    out_word.value  = upd.value;
                    out_word.last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_word.last = 1'b1;
                    if (r_hold_valid) begin
                        out_word.fired          = 1'b1;
                        out_word.fired_channel  = r_hold_ch;
                        out_word.callback_event = r_hold_cb;
                    end
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // channel memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= upd.entry;
        end
        if (rd_en) begin
            r_rd       <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_alloc      <= '0;
            r_handler    <= '0;
            r_hold_valid <= 1'b0;
            r_nrep       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hold_valid <= n_hold_valid;
            r_nrep       <= n_nrep;
            if (wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (commit && upd.alloc_we) begin
                r_alloc[r_addr] <= upd.alloc_val;
            end
            if (commit && upd.hnd_we) begin
                r_handler[r_addr] <= upd.hnd_val;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_addr       <= n_addr;
        r_free_found <= n_free_found;
        r_hold_ch    <= n_hold_ch;
        r_hold_cb    <= n_hold_cb;
        if (out_load) begin
            r_out <= out_word;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
